### hw/rtl/frame_animation_sequencer_macros.svh
// assertion macros for the frame animation sequencer checker
// no dependencies; included by the checker file only
`ifndef FRAME_ANIMATION_SEQUENCER_MACROS_SVH
`define FRAME_ANIMATION_SEQUENCER_MACROS_SVH

// same-cycle implication
`define FAS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/fas_pkg.sv
// shared constants, codes and types of the frame animation sequencer
// no dependencies; used by the frame ram, the top level and the checker
package fas_pkg;

   localparam int DEF_NUM_ANIMS  = 8;
   localparam int DEF_MAX_FRAMES = 16;
   localparam int DEF_WALK_LIMIT = 32;

   localparam int FUNC_W    = 3;
   localparam int ANIM_W    = 3;
   localparam int SPRITE_W  = 12;
   localparam int DUR_W     = 16;
   localparam int ELAPSED_W = 17;
   localparam int REQ_W     = 48;
   localparam int RSP_W     = 24;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEFINE  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SELECT  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RESTART = 3'd4;

   typedef struct packed {
      logic [SPRITE_W-1:0] sprite;
      logic [DUR_W-1:0]    length;
   } frame_word_type;

endpackage

### hw/rtl/fas_frame_mem.sv
// frame store: one synchronous ram of sprite number and duration per frame
// depends on fas_pkg for the word type
module fas_frame_mem #(
   parameter int DEPTH = fas_pkg::DEF_NUM_ANIMS * fas_pkg::DEF_MAX_FRAMES,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  fas_pkg::frame_word_type wr_data,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output fas_pkg::frame_word_type rd_data
);

   fas_pkg::frame_word_type mem_q [DEPTH];
   fas_pkg::frame_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
   end

   // registered read, held between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/frame_animation_sequencer.sv
// top level of the frame animation sequencer: command decode, tick walker, result register
// depends on fas_pkg and fas_frame_mem
//
//   channel | direction | tdata                                                   | tuser
//   req     | in        | anim_id, loop_flag, sprite_frame, duration_ms, delta_ms | func
//   rsp     | out       | shown_frame, finished, active_anim, has_active          | -
//
// one item at a time; define, append, select, restart and an idle tick go through the
// steps take, apply, frame read and result load, in that order
// a tick that walks visits at most WALK_LIMIT frames, each as a read and then a
// compare and subtract, set by the single read port of the frame ram
// a result waits in its output register while the next item is taken in; the sequencer
// stalls in its last step only when that register is still full
// reset clears all control state at once; frame ram entries are undefined until
// written, and the result reports no sprite read from one, so there is no clearing pass
module frame_animation_sequencer #(
   parameter int NUM_ANIMS  = fas_pkg::DEF_NUM_ANIMS,
   parameter int MAX_FRAMES = fas_pkg::DEF_MAX_FRAMES,
   parameter int WALK_LIMIT = fas_pkg::DEF_WALK_LIMIT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [2:0] anim_id, [3] loop_flag, [15:4] sprite_frame, [31:16] duration_ms,
   // [47:32] delta_ms
   input  logic [fas_pkg::REQ_W-1:0]  req_tdata,
   // [2:0] func
   input  logic [fas_pkg::FUNC_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [11:0] shown_frame, [12] finished, [15:13] active_anim, [16] has_active,
   // [23:17] zero
   output logic [fas_pkg::RSP_W-1:0]  rsp_tdata
);

   localparam int DEPTH = NUM_ANIMS * MAX_FRAMES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW    = $clog2(MAX_FRAMES + 1);
   localparam int NW    = $clog2(WALK_LIMIT + 1);
   localparam int IW    = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;

   localparam int AIDW = fas_pkg::ANIM_W;
   localparam int EW   = fas_pkg::ELAPSED_W;
   localparam int DW   = fas_pkg::DUR_W;
   localparam int SW   = fas_pkg::SPRITE_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_EXEC     = 3'd1;
   localparam logic [2:0] ST_WALK_RD  = 3'd2;
   localparam logic [2:0] ST_WALK_CMP = 3'd3;
   localparam logic [2:0] ST_SHOW_RD  = 3'd4;
   localparam logic [2:0] ST_RESP     = 3'd5;

   logic [2:0] state_ff, state_in;

   // held item
   logic [fas_pkg::FUNC_W-1:0] func_ff;
   logic [AIDW-1:0]            id_ff;
   logic                       loop_ff;
   logic [SW-1:0]              sprite_ff;
   logic [DW-1:0]              dur_ff;
   logic [DW-1:0]              delta_ff;

   // per-animation tables
   logic [CW-1:0] counts_ff [NUM_ANIMS];
   logic [CW-1:0] counts_in [NUM_ANIMS];
   logic [NUM_ANIMS-1:0] repeat_ff, repeat_in;
   logic [NUM_ANIMS-1:0] defined_ff, defined_in;

   // playback state, with a copy of the current animation's count and repeat flag
   logic [AIDW-1:0] cur_ff, cur_in;
   logic            valid_ff, valid_in;
   logic [EW-1:0]   elapsed_ff, elapsed_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   ccount_ff, ccount_in;
   logic            crep_ff, crep_in;
   logic [NW-1:0]   steps_ff, steps_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [fas_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // frame ram port
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   fas_pkg::frame_word_type wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   fas_pkg::frame_word_type rd_data;

   // decode helpers
   logic          req_xfer;
   logic          id_ok;
   logic [IW-1:0] idx;
   logic          cur_match;
   logic [EW:0]   elapsed_sum;
   logic [NW-1:0] steps_next;
   logic          last_frame;
   logic [SW-1:0] shown;

   function automatic logic [AW-1:0] frame_addr(input logic [AIDW-1:0] anim,
                                                input logic [PW-1:0] pos);
      return AW'(AW'(anim) * AW'(MAX_FRAMES)) + AW'(pos);
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   assign id_ok       = (int'(id_ff) < NUM_ANIMS);
   assign idx         = IW'(id_ff);
   assign cur_match   = valid_ff && (cur_ff == id_ff);
   assign elapsed_sum = {1'b0, elapsed_ff} + (EW + 1)'(delta_ff);
   assign steps_next  = steps_ff + NW'(1);
   assign last_frame  = ((CW'(pos_ff) + CW'(1)) == ccount_ff);
   assign shown       = (valid_ff && ccount_ff != '0) ? rd_data.sprite : '0;

   always_comb begin
      state_in     = state_ff;
      counts_in    = counts_ff;
      repeat_in    = repeat_ff;
      defined_in   = defined_ff;
      cur_in       = cur_ff;
      valid_in     = valid_ff;
      elapsed_in   = elapsed_ff;
      pos_in       = pos_ff;
      done_in      = done_ff;
      ccount_in    = ccount_ff;
      crep_in      = crep_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = frame_addr(id_ff, PW'(counts_ff[idx]));
      wr_data      = '{sprite: sprite_ff, length: dur_ff};
      rd_en        = 1'b0;
      rd_addr      = frame_addr(cur_ff, pos_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_SHOW_RD;
            unique case (func_ff)
               fas_pkg::FUNC_TICK: begin
                  if (valid_ff && !done_ff && ccount_ff != '0) begin
                     elapsed_in = elapsed_sum[EW] ? fas_pkg::ELAPSED_MAX : elapsed_sum[EW-1:0];
                     steps_in   = '0;
                     state_in   = ST_WALK_RD;
                  end
               end
               fas_pkg::FUNC_DEFINE: begin
                  if (id_ok) begin
                     defined_in[idx] = 1'b1;
                     counts_in[idx]  = '0;
                     repeat_in[idx]  = loop_ff;
                     if (!valid_ff || cur_ff == id_ff) begin
                        ccount_in = '0;
                        crep_in   = loop_ff;
                     end
                     if (!valid_ff) begin
                        cur_in   = id_ff;
                        valid_in = 1'b1;
                     end else if (cur_ff == id_ff) begin
                        elapsed_in = '0;
                        pos_in     = '0;
                        done_in    = 1'b0;
                     end
                  end
               end
               fas_pkg::FUNC_APPEND: begin
                  if (id_ok && defined_ff[idx] && counts_ff[idx] < CW'(MAX_FRAMES)) begin
                     wr_en          = 1'b1;
                     counts_in[idx] = counts_ff[idx] + CW'(1);
                     if (cur_match) begin
                        ccount_in = ccount_ff + CW'(1);
                     end
                  end
               end
               fas_pkg::FUNC_SELECT: begin
                  if (id_ok && defined_ff[idx] && !cur_match) begin
                     cur_in     = id_ff;
                     valid_in   = 1'b1;
                     ccount_in  = counts_ff[idx];
                     crep_in    = repeat_ff[idx];
                     elapsed_in = '0;
                     pos_in     = '0;
                     done_in    = 1'b0;
                  end
               end
               fas_pkg::FUNC_RESTART: begin
                  if (id_ok && defined_ff[idx] && cur_match) begin
                     elapsed_in = '0;
                     pos_in     = '0;
                     done_in    = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_WALK_RD: begin
            rd_en    = 1'b1;
            state_in = ST_WALK_CMP;
         end

         // one frame per visit: compare, subtract, then advance, wrap or finish
         ST_WALK_CMP: begin
            steps_in = steps_next;
            if (elapsed_ff < EW'(rd_data.length)) begin
               state_in = ST_SHOW_RD;
            end else begin
               elapsed_in = elapsed_ff - EW'(rd_data.length);
               if (last_frame && !crep_ff) begin
                  done_in  = 1'b1;
                  state_in = ST_SHOW_RD;
               end else begin
                  pos_in   = last_frame ? '0 : pos_ff + PW'(1);
                  state_in = (steps_next == NW'(WALK_LIMIT)) ? ST_SHOW_RD : ST_WALK_RD;
               end
            end
         end

         ST_SHOW_RD: begin
            rd_en    = 1'b1;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = fas_pkg::RSP_W'({valid_ff, cur_ff, done_ff, shown});
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int i = 0; i < NUM_ANIMS; i++) begin
            counts_ff[i] <= '0;
         end
         repeat_ff    <= '0;
         defined_ff   <= '0;
         cur_ff       <= '0;
         valid_ff     <= 1'b0;
         elapsed_ff   <= '0;
         pos_ff       <= '0;
         done_ff      <= 1'b0;
         ccount_ff    <= '0;
         crep_ff      <= 1'b0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counts_ff    <= counts_in;
         repeat_ff    <= repeat_in;
         defined_ff   <= defined_in;
         cur_ff       <= cur_in;
         valid_ff     <= valid_in;
         elapsed_ff   <= elapsed_in;
         pos_ff       <= pos_in;
         done_ff      <= done_in;
         ccount_ff    <= ccount_in;
         crep_ff      <= crep_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff   <= req_tuser;
         id_ff     <= req_tdata[2:0];
         loop_ff   <= req_tdata[3];
         sprite_ff <= req_tdata[15:4];
         dur_ff    <= req_tdata[31:16];
         delta_ff  <= req_tdata[47:32];
      end
      rsp_data_ff <= rsp_data_in;
   end

   fas_frame_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hw/rtl/fas_checker.sv
// port-level checks of the frame animation sequencer, bound to the top level
// depends on fas_pkg and frame_animation_sequencer_macros.svh
`include "frame_animation_sequencer_macros.svh"

module fas_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [fas_pkg::RSP_W-1:0] rsp_tdata
);

   logic        stall;
   logic        req_xfer;
   logic        idle_rsp;
   logic [15:0] rsp_state;

   assign stall     = rsp_tvalid && !rsp_tready;
   assign req_xfer  = req_tvalid && req_tready;
   assign idle_rsp  = rsp_tvalid && !rsp_tdata[16];
   assign rsp_state = rsp_tdata[15:0];

   // a waiting result stays offered and keeps its data
   `FAS_ASSERT_NEXT(a_rsp_hold, clock, reset, stall, rsp_tvalid, "result dropped while stalled")
   `FAS_ASSERT_NEXT(a_rsp_data, clock, reset, stall, $stable(rsp_tdata), "result data changed")

   // no result straight out of reset
   `FAS_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid, "result valid after reset")

   // one item at a time: after a transfer in, the input side closes
   `FAS_ASSERT_NEXT(a_req_single, clock, reset, req_xfer, !req_tready, "item taken while busy")

   // with no animation defined, everything reported is zero
   `FAS_ASSERT_SAME(a_rsp_idle, clock, reset, idle_rsp, rsp_state == '0, "nonzero idle report")

endmodule

bind frame_animation_sequencer fas_checker u_fas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
